[hw/rtl/tlr_pkg.sv]
package tlr_pkg;
   localparam int COORD_BITS_DEF = 13;
   localparam int MAX_STROKE_DEF = 15;
   localparam int CFG_BITS = 13;
   localparam int CFG_IDX_BITS = 2;
   localparam logic [CFG_IDX_BITS-1:0] CSR_RASTER_WIDTH = 2'd0;
   localparam logic [CFG_IDX_BITS-1:0] CSR_RASTER_HEIGHT = 2'd1;
   localparam logic [CFG_IDX_BITS-1:0] CSR_STROKE_WIDTH = 2'd2;
   localparam logic REQ_START = 1'b0;
   localparam logic REQ_ADVANCE = 1'b1;
endpackage

[hw/rtl/tlr_div.sv]
// Restoring divider: unsigned quotient of num by den, one bit a cycle.
module tlr_div #(
   parameter int NB = 32,
   parameter int DB = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NB-1:0] num,
   input  logic [DB-1:0] den,
   output logic          busy,
   output logic [NB-1:0] quot
);
   localparam int CB = $clog2(NB + 1);
   logic [NB-1:0] q_ff, q_in;
   logic [DB:0]   r_ff, r_in;
   logic [DB-1:0] d_ff;
   logic [CB-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic [DB:0]   trial;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      trial = {r_ff[DB-1:0], q_ff[NB-1]};
      if (start) begin
         q_in = num;
         r_in = '0;
         cnt_in = CB'(NB);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[NB-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NB-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CB'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      if (start) d_ff <= den;
   end

   assign busy = busy_ff;
   assign quot = q_ff;
endmodule

[hw/rtl/tlr_front.sv]
// Accept and classify request words; push them into a short queue.
module tlr_front #(
   parameter int CB = 13,
   parameter int DEPTH = 2
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic          req_type,
   input  logic [CB-1:0] req_start_x,
   input  logic [CB-1:0] req_start_y,
   input  logic [CB-1:0] req_end_x,
   input  logic [CB-1:0] req_end_y,
   output logic          q_valid,
   input  logic          q_pop,
   output logic          q_type,
   output logic          q_empty_seg,
   output logic [4*CB-1:0] q_coords
);
   import tlr_pkg::*;
   localparam int W = 4 * CB + 2;
   localparam int AB = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   logic [W-1:0] mem_ff [DEPTH];
   logic [AB-1:0] wp_ff, rp_ff;
   logic [AB:0]   cnt_ff;
   logic          push, miss_s, miss_e;
   logic [W-1:0]  head;

   assign miss_s = (req_start_x == {CB{1'b1}}) && (req_start_y == {CB{1'b1}});
   assign miss_e = (req_end_x == {CB{1'b1}}) && (req_end_y == {CB{1'b1}});
   assign req_stall = (cnt_ff == (AB+1)'(DEPTH));
   assign push = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= (wp_ff == AB'(DEPTH-1)) ? '0 : wp_ff + 1'b1;
         if (q_pop) rp_ff <= (rp_ff == AB'(DEPTH-1)) ? '0 : rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (AB+1)'(push) - (AB+1)'(q_pop);
      end
      if (push)
         mem_ff[wp_ff] <= {req_type, (req_type == REQ_START) && (miss_s || miss_e),
                           req_start_x, req_start_y, req_end_x, req_end_y};
   end

   assign head = mem_ff[rp_ff];
   assign q_valid = (cnt_ff != '0);
   assign q_type = head[W-1];
   assign q_empty_seg = head[W-2];
   assign q_coords = head[4*CB-1:0];
endmodule

[hw/rtl/tlr_back.sv]
// Segment setup and brush walk; one result word per queue word.
module tlr_back #(
   parameter int CB = 13,
   parameter int MAX_STROKE = 15
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          q_valid,
   output logic          q_pop,
   input  logic          q_type,
   input  logic          q_empty_seg,
   input  logic [4*CB-1:0] q_coords,
   input  logic [12:0]   cfg_width,
   input  logic [12:0]   cfg_height,
   input  logic [3:0]    cfg_stroke,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [CB-1:0] rsp_pix_x,
   output logic [CB-1:0] rsp_pix_y,
   output logic          rsp_pix_valid,
   output logic          rsp_inside_raster,
   output logic          rsp_last_pixel
);
   import tlr_pkg::*;
   localparam int DW = CB + 1;
   localparam int NB = 2 * CB + 6;
   localparam int HB = 5;
   typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_OUT} st_type;
   st_type st_ff;

   logic          act_ff, xmaj_ff, setup_ff, dgo_ff;
   logic signed [CB-1:0] ax_ff, ay_ff, pos_ff, end_ff, minc_ff;
   logic signed [DW-1:0] dmaj_ff, dmin_ff;
   logic [HB-1:0] bdx_ff, bdy_ff;
   logic signed [NB-1:0] num_ff;
   logic signed [DW:0]   den_ff;
   logic          neg_ff;
   logic [CB-1:0] ox_ff, oy_ff;
   logic          ov_ff, oin_ff, olast_ff, rv_ff;

   logic signed [CB:0] x1, y1, x2, y2, dx, dy, adx, ady;
   logic signed [CB-1:0] amaj, amin;
   logic [HB-1:0] h;
   logic [HB:0]   h2;
   logic signed [CB+1:0] px, py;
   logic signed [NB-1:0] nprod;
   logic signed [DW:0]   dden;
   logic [NB-1:0] num_abs;
   logic [DW-1:0] den_abs;
   logic          dv_start, dv_busy;
   logic [NB-1:0] dv_q;
   logic          out_free, out_load;

   tlr_div #(.NB(NB), .DB(DW)) u_div (
      .clock(clock), .reset(reset), .start(dv_start),
      .num(num_abs), .den(den_abs), .busy(dv_busy), .quot(dv_q)
   );

   assign x1 = (CB+1)'(signed'(q_coords[4*CB-1:3*CB]));
   assign y1 = (CB+1)'(signed'(q_coords[3*CB-1:2*CB]));
   assign x2 = (CB+1)'(signed'(q_coords[2*CB-1:CB]));
   assign y2 = (CB+1)'(signed'(q_coords[CB-1:0]));
   assign dx = x2 - x1;
   assign dy = y2 - y1;
   assign adx = dx[CB] ? -dx : dx;
   assign ady = dy[CB] ? -dy : dy;
   assign amaj = xmaj_ff ? ax_ff : ay_ff;
   assign amin = xmaj_ff ? ay_ff : ax_ff;
   assign h = ((HB'(cfg_stroke) > HB'(MAX_STROKE)) ? HB'(MAX_STROKE) : HB'(cfg_stroke)) >> 1;
   assign h2 = {h, 1'b0};
   assign px = (xmaj_ff ? (CB+2)'(pos_ff) : (CB+2)'(minc_ff))
               + (CB+2)'(signed'({1'b0, bdx_ff})) - (CB+2)'(signed'({1'b0, h}));
   assign py = (xmaj_ff ? (CB+2)'(minc_ff) : (CB+2)'(pos_ff))
               + (CB+2)'(signed'({1'b0, bdy_ff})) - (CB+2)'(signed'({1'b0, h}));
   // (2*amin+1)*dmaj + 2*dmin*(pos-amaj), both products in one stage
   assign nprod = NB'((2 * NB'(amin) + 1) * NB'(dmaj_ff))
                + NB'(2 * NB'(dmin_ff) * (NB'(pos_ff) - NB'(amaj)));
   assign dden = {dmaj_ff, 1'b0};
   assign num_abs = num_ff[NB-1] ? NB'(-num_ff) : NB'(num_ff);
   assign den_abs = DW'(den_ff[DW] ? -den_ff : den_ff);
   assign dv_start = (st_ff == ST_DIV) && !dgo_ff;
   assign out_free = !rv_ff || !rsp_stall;
   assign q_pop = q_valid && out_free && (st_ff == ST_IDLE);
   assign out_load = ((st_ff == ST_IDLE) && q_valid && out_free
                      && !(q_type == REQ_START && !q_empty_seg))
                   || ((st_ff == ST_OUT) && setup_ff && out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         act_ff <= 1'b0;
         xmaj_ff <= 1'b0;
         rv_ff <= 1'b0;
         setup_ff <= 1'b0;
         dgo_ff <= 1'b0;
         bdx_ff <= '0;
         bdy_ff <= '0;
      end else begin
         rv_ff <= out_load || (rv_ff && rsp_stall);
         unique case (st_ff)
            ST_IDLE: if (q_valid && out_free) begin
               if (q_type == REQ_START) begin
                  if (q_empty_seg) begin
                     act_ff <= 1'b0;
                     {ox_ff, oy_ff, ov_ff, oin_ff, olast_ff} <= {{2*CB{1'b0}}, 3'b001};
                  end else begin
                     ax_ff <= x1[CB-1:0];
                     ay_ff <= y1[CB-1:0];
                     xmaj_ff <= (adx >= ady);
                     dmaj_ff <= (adx >= ady) ? dx : dy;
                     dmin_ff <= (adx >= ady) ? dy : dx;
                     if (adx >= ady) begin
                        pos_ff <= (x1 < x2) ? x1[CB-1:0] : x2[CB-1:0];
                        end_ff <= (x1 < x2) ? x2[CB-1:0] : x1[CB-1:0];
                     end else begin
                        pos_ff <= (y1 < y2) ? y1[CB-1:0] : y2[CB-1:0];
                        end_ff <= (y1 < y2) ? y2[CB-1:0] : y1[CB-1:0];
                     end
                     bdx_ff <= '0;
                     bdy_ff <= '0;
                     act_ff <= 1'b1;
                     setup_ff <= 1'b1;
                     st_ff <= ST_MUL;
                  end
               end else if (!act_ff) begin
                  {ox_ff, oy_ff, ov_ff, oin_ff, olast_ff} <= {{2*CB{1'b0}}, 3'b001};
               end else begin
                  ox_ff <= px[CB-1:0];
                  oy_ff <= py[CB-1:0];
                  ov_ff <= 1'b1;
                  oin_ff <= !px[CB+1] && !py[CB+1]
                            && ((CB+2)'(cfg_width) > px) && ((CB+2)'(cfg_height) > py);
                  olast_ff <= 1'b0;
                  if ({1'b0, bdx_ff} < h2) bdx_ff <= bdx_ff + 1'b1;
                  else begin
                     bdx_ff <= '0;
                     if ({1'b0, bdy_ff} < h2) bdy_ff <= bdy_ff + 1'b1;
                     else begin
                        bdy_ff <= '0;
                        if (pos_ff >= end_ff) begin
                           olast_ff <= 1'b1;
                           act_ff <= 1'b0;
                        end else begin
                           pos_ff <= pos_ff + 1'b1;
                           st_ff <= ST_MUL;
                        end
                     end
                  end
               end
            end
            ST_MUL: begin
               num_ff <= nprod;
               den_ff <= dden;
               neg_ff <= dden[DW];
               dgo_ff <= 1'b0;
               if (dmin_ff == '0 || dmaj_ff == '0) begin
                  minc_ff <= amin;
                  st_ff <= ST_OUT;
               end else st_ff <= ST_DIV;
            end
            ST_DIV: begin
               dgo_ff <= 1'b1;
               if (dgo_ff && !dv_busy) begin
                  // truncate toward zero: restore sign
                  minc_ff <= (num_ff[NB-1] ^ neg_ff) ? CB'(-dv_q) : CB'(dv_q);
                  st_ff <= ST_OUT;
               end
            end
            ST_OUT: if (!setup_ff) st_ff <= ST_IDLE;
               else if (out_free) begin
                  {ox_ff, oy_ff, ov_ff, oin_ff, olast_ff} <= '0;
                  setup_ff <= 1'b0;
                  st_ff <= ST_IDLE;
               end
            default: st_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_pix_x = ox_ff;
   assign rsp_pix_y = oy_ff;
   assign rsp_pix_valid = ov_ff;
   assign rsp_inside_raster = oin_ff;
   assign rsp_last_pixel = olast_ff;
endmodule

[hw/rtl/thick_line_rasterizer_core.sv]
// Thick line rasterizer, square brush.
// An advance word inside a brush square goes through the queue and the result register;
// one word a cycle while the result is not stalled. An advance that moves to the next
// major position, and a start, hold the back part in its multiply and divide states (the
// bit-serial divider is skipped on axis-aligned lines); a start's result follows them.
// Synchronous active-high reset clears control state and the config registers
// to 1920 x 1080, stroke 1.
module thick_line_rasterizer_core #(
   parameter int COORD_BITS = tlr_pkg::COORD_BITS_DEF,
   parameter int MAX_STROKE = tlr_pkg::MAX_STROKE_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_write,
   input  logic [tlr_pkg::CFG_IDX_BITS-1:0] csr_index,
   input  logic [tlr_pkg::CFG_BITS-1:0] csr_data,
   input  logic req_valid,
   output logic req_stall,
   input  logic req_type,
   input  logic [COORD_BITS-1:0] req_start_x,
   input  logic [COORD_BITS-1:0] req_start_y,
   input  logic [COORD_BITS-1:0] req_end_x,
   input  logic [COORD_BITS-1:0] req_end_y,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [COORD_BITS-1:0] rsp_pix_x,
   output logic [COORD_BITS-1:0] rsp_pix_y,
   output logic rsp_pix_valid,
   output logic rsp_inside_raster,
   output logic rsp_last_pixel
);
   import tlr_pkg::*;
   logic [12:0] width_ff, height_ff;
   logic [3:0]  stroke_ff;
   logic q_valid, q_pop, q_type, q_empty_seg;
   logic [4*COORD_BITS-1:0] q_coords;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 13'd1920;
         height_ff <= 13'd1080;
         stroke_ff <= 4'd1;
      end else if (csr_write) begin
         case (csr_index)
            CSR_RASTER_WIDTH: width_ff <= csr_data;
            CSR_RASTER_HEIGHT: height_ff <= csr_data;
            CSR_STROKE_WIDTH: stroke_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   tlr_front #(.CB(COORD_BITS), .DEPTH(2)) u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_type(req_type), .req_start_x(req_start_x), .req_start_y(req_start_y),
      .req_end_x(req_end_x), .req_end_y(req_end_y), .q_valid(q_valid),
      .q_pop(q_pop), .q_type(q_type), .q_empty_seg(q_empty_seg), .q_coords(q_coords)
   );

   tlr_back #(.CB(COORD_BITS), .MAX_STROKE(MAX_STROKE)) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_pop(q_pop),
      .q_type(q_type), .q_empty_seg(q_empty_seg), .q_coords(q_coords),
      .cfg_width(width_ff), .cfg_height(height_ff), .cfg_stroke(stroke_ff),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_pix_x(rsp_pix_x),
      .rsp_pix_y(rsp_pix_y), .rsp_pix_valid(rsp_pix_valid),
      .rsp_inside_raster(rsp_inside_raster), .rsp_last_pixel(rsp_last_pixel)
   );

`ifndef ASSERT_OFF
   a_last_nopix: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pix_valid |-> !rsp_inside_raster && rsp_pix_x == '0
                                      && rsp_pix_y == '0)
      else $error("non-pixel word carries a position");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pix_x) && $stable(rsp_pix_y))
      else $error("stalled result changed");
   a_inside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_inside_raster |-> rsp_pix_valid)
      else $error("inside flag without pixel");
`endif
endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
   import tlr_pkg::*;

   localparam int CB = COORD_BITS_DEF;
   localparam int MAXS = MAX_STROKE_DEF;

   typedef struct packed {
      logic [CB-1:0] px;
      logic [CB-1:0] py;
      logic          pv;
      logic          in_r;
      logic          last;
   } pixel_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_write = 0;
   logic [CFG_IDX_BITS-1:0] csr_index = '0;
   logic [CFG_BITS-1:0] csr_data = '0;
   logic req_valid = 0;
   logic req_stall;
   logic req_type = 0;
   logic [CB-1:0] req_start_x = '0, req_start_y = '0, req_end_x = '0, req_end_y = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [CB-1:0] rsp_pix_x, rsp_pix_y;
   logic rsp_pix_valid, rsp_inside_raster, rsp_last_pixel;

   thick_line_rasterizer_core u_dut (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   // predictor state
   int unsigned cfg_w, cfg_h, cfg_s;
   bit  seg_on, x_major;
   int  anc_x, anc_y, d_maj, d_min, maj_pos, maj_end, min_ctr;
   int unsigned bdx, bdy;

   pixel_type pixel_q[$];
   int errors = 0;
   int n_items = 0, n_pixels = 0, n_segments = 0;
   int send_idle = 0, recv_idle = 0;
   bit hold_rsp = 0;

   function automatic int sx(logic [CB-1:0] v);
      return int'($signed(v));
   endfunction

   function automatic int minor_of(int pos);
      longint num, den;
      int amaj, amin;
      amaj = x_major ? anc_x : anc_y;
      amin = x_major ? anc_y : anc_x;
      if (d_min == 0 || d_maj == 0) return amin;
      num = (2 * longint'(amin) + 1) * longint'(d_maj)
            + 2 * longint'(d_min) * (longint'(pos) - longint'(amaj));
      den = 2 * longint'(d_maj);
      if (den < 0) begin
         num = -num;
         den = -den;
      end
      return int'(num / den);
   endfunction

   function automatic pixel_type predict_pixel(logic typ, logic [CB-1:0] a, b, c, d);
      pixel_type r;
      int x1, y1, x2, y2, dx, dy, adx, ady, p0, p1, ox, oy, px, py;
      int unsigned hw;
      r = '0;
      if (typ == REQ_START) begin
         x1 = sx(a); y1 = sx(b); x2 = sx(c); y2 = sx(d);
         if ((x1 == -1 && y1 == -1) || (x2 == -1 && y2 == -1)) begin
            seg_on = 0;
            r.last = 1;
            return r;
         end
         dx = x2 - x1; dy = y2 - y1;
         adx = dx < 0 ? -dx : dx;
         ady = dy < 0 ? -dy : dy;
         anc_x = x1; anc_y = y1;
         x_major = adx >= ady;
         d_maj = x_major ? dx : dy;
         d_min = x_major ? dy : dx;
         p0 = x_major ? x1 : y1;
         p1 = x_major ? x2 : y2;
         maj_pos = p0 < p1 ? p0 : p1;
         maj_end = p0 < p1 ? p1 : p0;
         min_ctr = minor_of(maj_pos);
         bdx = 0; bdy = 0;
         seg_on = 1;
         return r;
      end
      if (!seg_on) begin
         r.last = 1;
         return r;
      end
      hw = (cfg_s > MAXS ? MAXS : cfg_s) / 2;
      ox = int'(bdx) - int'(hw);
      oy = int'(bdy) - int'(hw);
      px = x_major ? maj_pos + ox : min_ctr + ox;
      py = x_major ? min_ctr + oy : maj_pos + oy;
      r.px = px[CB-1:0];
      r.py = py[CB-1:0];
      r.pv = 1;
      r.in_r = px >= 0 && py >= 0 && px < int'(cfg_w) && py < int'(cfg_h);
      if (bdx < 2 * hw) bdx++;
      else begin
         bdx = 0;
         if (bdy < 2 * hw) bdy++;
         else begin
            bdy = 0;
            if (maj_pos >= maj_end) begin
               r.last = 1;
               seg_on = 0;
            end else begin
               maj_pos++;
               min_ctr = minor_of(maj_pos);
            end
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      errors++;
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
   endtask

   // result checker
   always @(posedge clock) begin
      pixel_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pixel_q.size() == 0) report_mismatch("unexpected word", 1, 0);
         else begin
            e = pixel_q.pop_front();
            n_pixels++;
            if (rsp_pix_x !== e.px) report_mismatch("pix_x", sx(rsp_pix_x), sx(e.px));
            if (rsp_pix_y !== e.py) report_mismatch("pix_y", sx(rsp_pix_y), sx(e.py));
            if (rsp_pix_valid !== e.pv) report_mismatch("pix_valid", rsp_pix_valid, e.pv);
            if (rsp_inside_raster !== e.in_r)
               report_mismatch("inside_raster", rsp_inside_raster, e.in_r);
            if (rsp_last_pixel !== e.last)
               report_mismatch("last_pixel", rsp_last_pixel, e.last);
         end
      end
   end

   // receiver stall
   always @(negedge clock) begin
      rsp_stall <= hold_rsp || ($urandom_range(99) < recv_idle);
   end

   task automatic send_word(logic typ, logic [CB-1:0] a, b, c, d);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_type <= typ;
      req_start_x <= a; req_start_y <= b; req_end_x <= c; req_end_y <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pixel_q.push_back(predict_pixel(typ, a, b, c, d));
      n_items++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (pixel_q.size() != 0) @(negedge clock);
      repeat (2 * CB + 20) @(negedge clock);
   endtask

   task automatic write_csr(logic [CFG_IDX_BITS-1:0] idx, int unsigned v);
      drain();
      csr_write <= 1; csr_index <= idx; csr_data <= v[CFG_BITS-1:0];
      @(negedge clock);
      csr_write <= 0;
      if (idx == CSR_RASTER_WIDTH) cfg_w = v & 13'h1fff;
      else if (idx == CSR_RASTER_HEIGHT) cfg_h = v & 13'h1fff;
      else cfg_s = v & 4'hf;
   endtask

   function automatic logic [CB-1:0] rnd_coord();
      int k;
      k = $urandom_range(99);
      if (k < 5) return '1;
      if (k < 10) return CB'(4095);
      if (k < 15) return CB'($urandom);
      return CB'($urandom_range(60));
   endfunction

   task automatic send_segment(int short_len);
      logic [CB-1:0] a, b, c, d;
      int steps;
      a = rnd_coord(); b = rnd_coord();
      c = CB'(sx(a) + $signed($urandom_range(2 * short_len)) - short_len);
      d = CB'(sx(b) + $signed($urandom_range(2 * short_len)) - short_len);
      if ($urandom_range(9) == 0) begin
         c = rnd_coord(); d = rnd_coord();
      end
      send_word(REQ_START, a, b, c, d);
      n_segments++;
      steps = $urandom_range(40);
      repeat (steps) send_word(REQ_ADVANCE, CB'($urandom), CB'($urandom),
                               CB'($urandom), CB'($urandom));
   endtask

   task automatic test_directed();
      write_csr(CSR_STROKE_WIDTH, 1);
      send_word(REQ_ADVANCE, '0, '0, '0, '0);             // idle advance
      send_word(REQ_START, '1, '1, 13'd5, 13'd5);          // empty start
      send_word(REQ_START, 13'd5, 13'd5, '1, '1);          // empty end
      send_word(REQ_ADVANCE, '1, '1, '1, '1);
      send_word(REQ_START, 13'd3, 13'd3, 13'd3, 13'd3);    // single point
      repeat (2) send_word(REQ_ADVANCE, '0, '0, '0, '0);
      send_word(REQ_START, '1, 13'd2, 13'd2, '1);          // -1 on one axis only
      repeat (5) send_word(REQ_ADVANCE, '0, '0, '0, '0);
      send_word(REQ_START, 13'd10, 13'd0, 13'd0, 13'd3);   // reversed, x major
      repeat (4) send_word(REQ_ADVANCE, '0, '0, '0, '0);
      send_word(REQ_START, 13'd4095, 13'd4095, 13'd4093, 13'd4090); // y major
      repeat (8) send_word(REQ_ADVANCE, '0, '0, '0, '0);
      write_csr(CSR_STROKE_WIDTH, 15);
      send_word(REQ_START, 13'd0, 13'd0, 13'd1, 13'd0);
      repeat (70) send_word(REQ_ADVANCE, '0, '0, '0, '0);
      // shrink the brush in the middle of a square
      send_word(REQ_START, 13'd1919, 13'd1079, 13'd1921, 13'd1081);
      repeat (30) send_word(REQ_ADVANCE, '0, '0, '0, '0);
      write_csr(CSR_STROKE_WIDTH, 2);
      repeat (20) send_word(REQ_ADVANCE, '0, '0, '0, '0);
   endtask

   task automatic test_random(int n);
      int target;
      target = n_items + n;
      while (n_items < target) send_segment($urandom_range(1) ? 8 : 40);
   endtask

   task automatic test_configs();
      write_csr(CSR_RASTER_WIDTH, 1);
      write_csr(CSR_RASTER_HEIGHT, 1);
      write_csr(CSR_STROKE_WIDTH, 0);
      test_random(150);
      write_csr(CSR_RASTER_WIDTH, 4096);
      write_csr(CSR_RASTER_HEIGHT, 4096);
      write_csr(CSR_STROKE_WIDTH, 4);
      test_random(150);
      write_csr(CSR_RASTER_WIDTH, 40);
      write_csr(CSR_RASTER_HEIGHT, 25);
      write_csr(CSR_STROKE_WIDTH, 7);
      test_random(150);
   endtask

   task automatic test_idle_phases();
      write_csr(CSR_RASTER_WIDTH, 30 + $urandom_range(30));
      write_csr(CSR_RASTER_HEIGHT, 30 + $urandom_range(30));
      write_csr(CSR_STROKE_WIDTH, $urandom_range(15));
      send_idle = 54; recv_idle = 0;  test_random(300);
      send_idle = 0;  recv_idle = 54; test_random(300);
      send_idle = 24; recv_idle = 24; test_random(300);
      send_idle = 0;  recv_idle = 0;  test_random(300);
   endtask

   task automatic test_backpressure();
      int held;
      fork
         begin
            hold_rsp = 1;
            held = 0;
            while (held < 400) begin
               @(posedge clock);
               held++;
            end
            hold_rsp = 0;
         end
         test_random(100);
      join
   endtask

   initial begin
      cfg_w = 1920; cfg_h = 1080; cfg_s = 1;
      seg_on = 0; x_major = 0;
      anc_x = 0; anc_y = 0; d_maj = 0; d_min = 0;
      maj_pos = 0; maj_end = 0; min_ctr = 0; bdx = 0; bdy = 0;
      repeat (3) @(negedge clock);
      reset <= 0;
      @(negedge clock);
      test_directed();
      test_configs();
      test_backpressure();
      test_idle_phases();
      drain();
      $display("covered %0d words, %0d segments, %0d results checked", n_items,
               n_segments, n_pixels);
      $display("brush 0..15, raster sizes 1..4096, idle and stall phases, long hold-off");
      if (errors == 0)
         $display("thick_line_rasterizer_core test passed");
      else
         $display("thick_line_rasterizer_core test failed");
      $finish;
   end

   initial begin
      #20ms;
      $display("thick_line_rasterizer_core test failed");
      $finish;
   end
endmodule
